### sv/tea_pkg.sv
// ----------------------------------------------------------------------------
// tea_pkg
// Shared types, constants and round-sum function for the TEA cipher pipeline.
// ----------------------------------------------------------------------------
package tea_pkg;

    localparam int unsigned ROUNDS = 32;
    localparam int unsigned STAGES = 2 * ROUNDS;
    localparam int unsigned WORD_W = 32;

    localparam logic [WORD_W-1:0] TEA_DELTA = 32'h9E37_79B9;

    // per-item operation carried in tuser
    localparam logic CMD_ENCRYPT = 1'b0;
    localparam logic CMD_DECRYPT = 1'b1;

    // key register indexes
    localparam logic [1:0] KEY_IDX0 = 2'd0;
    localparam logic [1:0] KEY_IDX1 = 2'd1;
    localparam logic [1:0] KEY_IDX2 = 2'd2;
    localparam logic [1:0] KEY_IDX3 = 2'd3;

    typedef logic [WORD_W-1:0] word_t;

    typedef struct packed {
        word_t k0;
        word_t k1;
        word_t k2;
        word_t k3;
    } tea_key_t;

    typedef struct packed {
        logic  cmd;
        word_t x;
        word_t y;
    } tea_item_t;

    // delta * n, modulo 2^32; only ever called with elaboration constants
    function automatic word_t round_sum(input int unsigned n);
        logic [63:0] prod;
        prod = 64'(TEA_DELTA) * 64'(n);
        return prod[WORD_W-1:0];
    endfunction

endpackage

### sv/tea_stage.sv
// ----------------------------------------------------------------------------
// tea_stage
// One registered half round. Encryption adds the mix term, decryption
// subtracts it; which word is updated follows the half and the command.
// ----------------------------------------------------------------------------
module tea_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               half,
    input  tea_pkg::word_t     sum_enc,
    input  tea_pkg::word_t     sum_dec,
    input  tea_pkg::tea_key_t  key,
    input  logic               in_valid,
    input  tea_pkg::tea_item_t in_item,
    output logic               out_valid,
    output tea_pkg::tea_item_t out_item
);
    import tea_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    tea_item_t item_reg;
    tea_item_t item_next;

    logic  upd_x;
    word_t src;
    word_t dst;
    word_t ka;
    word_t kb;
    word_t sum;
    word_t mix;
    word_t res;

    // encrypt: first half updates x, second y; decrypt the other way round
    assign upd_x = (half == in_item.cmd);
    assign src   = upd_x ? in_item.y : in_item.x;
    assign dst   = upd_x ? in_item.x : in_item.y;
    assign ka    = upd_x ? key.k0 : key.k2;
    assign kb    = upd_x ? key.k1 : key.k3;
    assign sum   = (in_item.cmd == CMD_DECRYPT) ? sum_dec : sum_enc;

    assign mix = ((src << 4) + ka) ^ (src + sum) ^ ((src >> 5) + kb);
    assign res = (in_item.cmd == CMD_DECRYPT) ? (dst - mix) : (dst + mix);

    always_comb
    begin
        item_next     = in_item;
        if (upd_x)
        begin
            item_next.x = res;
        end
        else
        begin
            item_next.y = res;
        end
        valid_next = en ? in_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

### sv/tea_obuf.sv
// ----------------------------------------------------------------------------
// tea_obuf
// Output register with a skid entry. Ready towards the pipeline depends only
// on local state, so back pressure does not reach the input combinationally.
// ----------------------------------------------------------------------------
module tea_obuf (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  tea_pkg::tea_item_t in_item,
    output logic               out_valid,
    input  logic               out_ready,
    output tea_pkg::tea_item_t out_item
);
    import tea_pkg::*;

    logic      out_valid_reg;
    logic      out_valid_next;
    logic      skid_valid_reg;
    logic      skid_valid_next;
    tea_item_t out_item_reg;
    tea_item_t out_item_next;
    tea_item_t skid_item_reg;
    tea_item_t skid_item_next;

    logic push;
    logic pop;

    assign in_ready = !skid_valid_reg;
    assign push     = in_valid && in_ready;
    assign pop      = out_valid_reg && out_ready;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_item_next   = out_item_reg;
        skid_item_next  = skid_item_reg;
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_item_next   = skid_item_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || pop)
            begin
                out_item_next  = in_item;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_item_next  = in_item;
                skid_valid_next = 1'b1;
            end
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg  <= out_item_next;
        skid_item_reg <= skid_item_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // skid entry is only ever used behind a held output
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid with empty output register");

    // a transfer arriving behind a stalled output lands in the skid entry
    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (push && out_valid_reg && !out_ready) |=> skid_valid_reg)
        else $error("item lost behind stalled output");

    // a held skid entry keeps its contents until the output drains
    a_skid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && !out_ready) |=> (skid_valid_reg && $stable(skid_item_reg)))
        else $error("skid entry changed while stalled");

endmodule

### sv/tea_block_cipher.sv
// ----------------------------------------------------------------------------
// tea_block_cipher
// TEA encrypt/decrypt engine, one half round per pipeline stage.
//
//  channel  | dir | handshake                     | payload
//  ---------+-----+-------------------------------+-------------------------
//  s_axis   | in  | s_axis_tvalid / s_axis_tready | tdata 64b, tuser cmd
//  m_axis   | out | m_axis_tvalid / m_axis_tready | tdata 64b
//  cfg      | in  | cfg_we (no wait)              | cfg_index, cfg_wdata
//
//  One block per cycle sustained while the skid entry stays empty; each block
//  passes one registered half round per stage, then the output register.
//  Reset clears the key registers and all stage valid bits.
//  Back pressure first fills the output register and skid entry; once the
//  skid entry is full the whole pipeline and s_axis_tready hold.
// ----------------------------------------------------------------------------
module tea_block_cipher (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // [31:0] block_first, [63:32] block_second
    input  logic        s_axis_tuser,  // [0] cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,  // [31:0] result_first, [63:32] result_second
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wdata
);
    import tea_pkg::*;

    tea_key_t key_reg;
    tea_key_t key_next;

    logic      en;
    logic      stage_valid [STAGES+1];
    tea_item_t stage_item  [STAGES+1];
    tea_item_t res_item;

    always_comb
    begin
        key_next = key_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                KEY_IDX0: key_next.k0 = cfg_wdata;
                KEY_IDX1: key_next.k1 = cfg_wdata;
                KEY_IDX2: key_next.k2 = cfg_wdata;
                KEY_IDX3: key_next.k3 = cfg_wdata;
                default:  key_next    = key_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= '0;
        end
        else
        begin
            key_reg <= key_next;
        end
    end

    assign s_axis_tready      = en;
    assign stage_valid[0]     = s_axis_tvalid;
    assign stage_item[0].cmd  = s_axis_tuser;
    assign stage_item[0].x    = s_axis_tdata[31:0];
    assign stage_item[0].y    = s_axis_tdata[63:32];

    // stage 2r+h: half h of round r; decryption walks the sums downwards
    for (genvar s = 0; s < STAGES; s++)
    begin : g_stage
        tea_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .half      (1'(s % 2)),
            .sum_enc   (round_sum(s / 2 + 1)),
            .sum_dec   (round_sum(ROUNDS - s / 2)),
            .key       (key_reg),
            .in_valid  (stage_valid[s]),
            .in_item   (stage_item[s]),
            .out_valid (stage_valid[s+1]),
            .out_item  (stage_item[s+1])
        );
    end

    tea_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (stage_valid[STAGES]),
        .in_ready  (en),
        .in_item   (stage_item[STAGES]),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_item  (res_item)
    );

    assign m_axis_tdata = {res_item.y, res_item.x};

endmodule
